FILE: hdl/lsir_pkg.sv
`default_nettype none

package lsir_pkg;

    // Width of the conversion wait counter.
    localparam int WAIT_WIDTH = 16;
    // Width used to compare the counter with the wait_ticks register.
    localparam int WAIT_CMP_W = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_WAIT       = 5'd12;
    localparam logic [STEP_W-1:0] STEP_AFTER_WAIT = 5'd13;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd20;

    // floor(raw * 640 / 3) equals (raw * LUX_MULT) >> LUX_SHIFT for every 16-bit raw.
    localparam logic [25:0] LUX_MULT  = 26'd55924054;
    localparam int          LUX_SHIFT = 18;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_POWER_COMMAND  = 2'd1,
        REG_MODE_COMMAND   = 2'd2,
        REG_WAIT_TICKS     = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_WRITE = 3'd1,
        K_ACK   = 3'd2,
        K_STOP  = 3'd3,
        K_READ  = 3'd4,
        K_HACK  = 3'd5,
        K_WAIT  = 3'd6
    } kind_t;

    typedef struct packed {
        logic start_request;
        logic sda_in;
    } item_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] raw_count;
        logic [23:0] lux_q8;
        logic [4:0]  nack_flags;
    } result_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  power_command;
        logic [7:0]  mode_command;
        logic [15:0] wait_ticks;
    } cfg_t;

    // One bus tick as produced by the sequencer, before the lux conversion.
    typedef struct packed {
        logic        scl_level;
        logic        sda_drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] raw_count;
        logic [4:0]  nack_flags;
    } tick_t;

    function automatic kind_t plan_kind(input logic [STEP_W-1:0] step);
        kind_t k;
        case (step)
            5'd0, 5'd6, 5'd13:               k = K_START;
            5'd1, 5'd3, 5'd7, 5'd9, 5'd14:   k = K_WRITE;
            5'd2, 5'd4, 5'd8, 5'd10, 5'd15:  k = K_ACK;
            5'd5, 5'd11, 5'd20:              k = K_STOP;
            5'd12:                           k = K_WAIT;
            5'd16, 5'd18:                    k = K_READ;
            5'd17, 5'd19:                    k = K_HACK;
            default:                         k = K_STOP;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] plan_arg(input logic [STEP_W-1:0] step);
        logic [2:0] a;
        case (step)
            5'd3, 5'd4, 5'd18, 5'd19, 5'd20: a = 3'd1;
            5'd8, 5'd9:                      a = 3'd2;
            5'd10, 5'd14:                    a = 3'd3;
            5'd15:                           a = 3'd4;
            default:                         a = 3'd0;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] write_byte(input logic [2:0] which, input cfg_t cfg);
        logic [7:0] b;
        case (which)
            3'd0:    b = {cfg.device_address, 1'b0};
            3'd1:    b = cfg.power_command;
            3'd2:    b = cfg.mode_command;
            default: b = {cfg.device_address, 1'b1};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lsir_seq.sv
`default_nettype none

module lsir_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire lsir_pkg::item_t item,
    input  wire lsir_pkg::cfg_t  cfg,
    output lsir_pkg::tick_t      tick
);

    logic                             busy_reg, busy_next;
    logic [lsir_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [1:0]                       phase_reg, phase_next;
    logic [2:0]                       index_reg, index_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [lsir_pkg::WAIT_WIDTH-1:0]  wait_reg, wait_next;
    logic [15:0]                      reading_reg, reading_next;
    logic [4:0]                       nack_reg, nack_next;
    lsir_pkg::tick_t                  tick_reg, tick_next;

    logic [lsir_pkg::WAIT_CMP_W-1:0]  wait_ext, ticks_ext, wait_max, wait_target;
    logic                             run, bitwise, scl, drv, done;
    logic [1:0]                       ph;
    lsir_pkg::kind_t                  kind;
    logic [2:0]                       arg;

    always_comb
    begin
        wait_ext    = lsir_pkg::WAIT_CMP_W'(wait_reg);
        ticks_ext   = lsir_pkg::WAIT_CMP_W'(cfg.wait_ticks);
        wait_max    = lsir_pkg::WAIT_CMP_W'({lsir_pkg::WAIT_WIDTH{1'b1}});
        wait_target = (ticks_ext > wait_max) ? wait_max : ticks_ext;
    end

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        index_next   = index_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        reading_next = reading_reg;
        nack_next    = nack_reg;
        scl          = 1'b1;
        drv          = 1'b0;
        done         = 1'b0;
        run          = 1'b0;
        bitwise      = 1'b0;
        kind         = lsir_pkg::K_STOP;
        arg          = 3'd0;
        ph           = 2'd0;

        // A request on an idle tick starts the sequence in that same tick.
        if (!busy_reg && item.start_request)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            phase_next = 2'd0;
            index_next = 3'd0;
            nack_next  = 5'd0;
        end

        if (busy_next)
        begin
            if (step_next == lsir_pkg::STEP_WAIT)
            begin
                // Once the wait is over the third start begins in the same tick.
                if (wait_ext >= wait_target)
                begin
                    step_next  = lsir_pkg::STEP_AFTER_WAIT;
                    phase_next = 2'd0;
                    index_next = 3'd0;
                    run        = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            else
            begin
                run = 1'b1;
            end
        end

        if (run)
        begin
            kind = lsir_pkg::plan_kind(step_next);
            arg  = lsir_pkg::plan_arg(step_next);
            ph   = (phase_next == 2'd3) ? 2'd2 : phase_next;

            case (kind)
                lsir_pkg::K_START:
                begin
                    scl = (ph < 2'd2);
                    drv = (ph > 2'd0);
                end
                lsir_pkg::K_STOP:
                begin
                    scl  = (ph > 2'd0);
                    drv  = (ph < 2'd2);
                    done = (arg != 3'd0) && (ph == 2'd2);
                end
                lsir_pkg::K_WRITE:
                begin
                    bitwise = 1'b1;
                    if (ph == 2'd0 && index_next == 3'd0)
                    begin
                        shift_next = lsir_pkg::write_byte(arg, cfg);
                    end
                    scl = (ph == 2'd1);
                    drv = ~shift_next[7];
                    if (ph == 2'd2)
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                end
                lsir_pkg::K_ACK:
                begin
                    scl = (ph == 2'd1);
                    if (ph == 2'd1 && item.sda_in)
                    begin
                        nack_next = nack_next | (5'd1 << arg);
                    end
                end
                lsir_pkg::K_READ:
                begin
                    bitwise = 1'b1;
                    scl     = (ph == 2'd1);
                    if (ph == 2'd1)
                    begin
                        shift_next = {shift_next[6:0], item.sda_in};
                    end
                    if (ph == 2'd2 && index_next == 3'd7)
                    begin
                        if (arg == 3'd0)
                        begin
                            reading_next[15:8] = shift_next;
                        end
                        else
                        begin
                            reading_next[7:0] = shift_next;
                        end
                    end
                end
                lsir_pkg::K_HACK:
                begin
                    scl = (ph == 2'd1);
                    drv = (arg == 3'd0);
                end
                default:
                begin
                    scl = 1'b1;
                    drv = 1'b0;
                end
            endcase

            if (ph == 2'd2)
            begin
                if (bitwise && index_next != 3'd7)
                begin
                    phase_next = 2'd0;
                    index_next = index_next + 3'd1;
                end
                else
                begin
                    phase_next = 2'd0;
                    index_next = 3'd0;
                    if (step_next == lsir_pkg::STEP_LAST)
                    begin
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                    else
                    begin
                        step_next = step_next + 1'b1;
                        if (step_next == lsir_pkg::STEP_WAIT)
                        begin
                            wait_next = '0;
                        end
                    end
                end
            end
            else
            begin
                phase_next = ph + 2'd1;
            end
        end

        tick_next.scl_level     = scl;
        tick_next.sda_drive_low = drv;
        tick_next.busy_res      = busy_reg | item.start_request;
        tick_next.done_res      = done;
        tick_next.raw_count     = reading_next;
        tick_next.nack_flags    = nack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            phase_reg   <= 2'd0;
            index_reg   <= 3'd0;
            shift_reg   <= 8'd0;
            wait_reg    <= '0;
            reading_reg <= 16'd0;
            nack_reg    <= 5'd0;
        end
        else if (load)
        begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            reading_reg <= reading_next;
            nack_reg    <= nack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg <= tick_next;
        end
    end

    assign tick = tick_reg;

endmodule

`default_nettype wire

FILE: hdl/lsir_lux.sv
`default_nettype none

module lsir_lux (
    input  wire lsir_pkg::tick_t  tick,
    output lsir_pkg::result_t     result
);

    logic [41:0] product;

    // Division by 1.2 as a multiply by a scaled reciprocal; exact for 16-bit counts.
    assign product = 42'(tick.raw_count) * 42'(lsir_pkg::LUX_MULT);

    always_comb
    begin
        result.scl_level     = tick.scl_level;
        result.sda_drive_low = tick.sda_drive_low;
        result.busy_res      = tick.busy_res;
        result.done_res      = tick.done_res;
        result.raw_count     = tick.raw_count;
        result.lux_q8        = product[lsir_pkg::LUX_SHIFT +: 24];
        result.nack_flags    = tick.nack_flags;
    end

endmodule

`default_nettype wire

FILE: hdl/light_sensor_i2c_reader_unit.sv
// Bit-level I2C master that runs one light-sensor measurement per request.
// Each item transferred on the item channel is one bus tick: start_request
// asks for a new measurement (ignored while one is running) and sda_in is
// the sampled data line level. Each item yields exactly one result transfer
// carrying the clock level and data pull-down for that tick, busy and done
// flags, the 16-bit raw count, lux in Q8 (raw / 1.2) and five NACK flags.
// On the way from item transfer to result valid, the sequencer state and
// tick outputs are registered in the tick register, and the lux multiply is
// registered into the output register. One item is taken every cycle while
// item_ready is high; the only loop is the sequencer state update, closed
// through its own registers. When the receiver stalls, the output and tick
// registers both hold, and item_ready falls only once both are full.
// Configuration registers (device address, power command, mode command,
// wait ticks) are written through cfg_write/cfg_index/cfg_data and should
// only be written while no measurement is in flight. Reset clears the
// sequencer to idle, the reading and flags to zero, restores the default
// configuration and empties the pipeline.
`default_nettype none

module light_sensor_i2c_reader_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire lsir_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output lsir_pkg::result_t      result,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    lsir_pkg::cfg_t    cfg_reg;
    logic              s1_valid_reg;
    logic              result_valid_reg;
    lsir_pkg::result_t result_reg;
    lsir_pkg::tick_t   tick;
    lsir_pkg::result_t lux_result;
    logic              s1_ready;
    logic              accept;

    // Configuration registers; a write lands on the edge where cfg_write is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 7'd35;
            cfg_reg.power_command  <= 8'd1;
            cfg_reg.mode_command   <= 8'd16;
            cfg_reg.wait_ticks     <= 16'd36000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lsir_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                lsir_pkg::REG_POWER_COMMAND:  cfg_reg.power_command  <= cfg_data[7:0];
                lsir_pkg::REG_MODE_COMMAND:   cfg_reg.mode_command   <= cfg_data[7:0];
                lsir_pkg::REG_WAIT_TICKS:     cfg_reg.wait_ticks     <= cfg_data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The tick register advances when it is empty or its content moves on,
    // and it moves on whenever the output register is empty or being drained.
    assign s1_ready   = !result_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s1_ready;
    assign accept     = item_valid && item_ready;

    lsir_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .item  (item),
        .cfg   (cfg_reg),
        .tick  (tick)
    );

    lsir_lux u_lux (
        .tick   (tick),
        .result (lux_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s1_ready)
            begin
                result_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_reg)
        begin
            result_reg <= lux_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // With the output register empty the block must always be able to take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> item_ready)
        else $error("item channel stalled with an empty output register");

    // Outside a sequence the bus is left idle: clock high, data released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !tick.busy_res) |-> (tick.scl_level && !tick.sda_drive_low))
        else $error("bus driven while the sequencer is idle");

    // The final stop ends with the clock high and the data line released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && tick.done_res) |->
            (tick.busy_res && tick.scl_level && !tick.sda_drive_low))
        else $error("done flagged outside the final stop condition");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_light_sensor_i2c_reader_unit.sv
`timescale 1ns / 1ps

module tb_light_sensor_i2c_reader_unit;

    // Sequencer step used while no measurement runs, and the total number of
    // plan steps. The plan itself is listed in plan_at below.
    localparam logic [5:0] STEP_IDLE  = 6'd63;
    localparam logic [5:0] STEP_DELAY = {1'b0, lsir_pkg::STEP_WAIT};
    localparam logic [5:0] STEP_END   = {1'b0, lsir_pkg::STEP_LAST} + 6'd1;

    // Which byte a write element sends.
    localparam logic [2:0] BYTE_ADDR_WR = 3'd0;
    localparam logic [2:0] BYTE_POWER   = 3'd1;
    localparam logic [2:0] BYTE_MODE    = 3'd2;
    localparam logic [2:0] BYTE_ADDR_RD = 3'd3;
    // Which half of the reading a read element fills.
    localparam logic [2:0] READ_HIGH = 3'd0;
    localparam logic [2:0] READ_LOW  = 3'd1;
    // Host acknowledge after a read byte: ACK after the high byte, NACK after the low.
    localparam logic [2:0] HOST_ACK  = 3'd0;
    localparam logic [2:0] HOST_NACK = 3'd1;
    // The last stop of the sequence is the one that raises done.
    localparam logic [2:0] STOP_PLAIN = 3'd0;
    localparam logic [2:0] STOP_FINAL = 3'd1;

    // Ticks of one full measurement, not counting the conversion wait.
    localparam int SEQ_TICKS = 207;

    // How the sensor side drives the data line during a measurement.
    localparam int SDA_RANDOM = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_LOW    = 2;
    // How start_request behaves while the measurement is running.
    localparam int REQ_SPARSE = 0;
    localparam int REQ_HOLD   = 1;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_TAIL  = 16;

    typedef struct packed {
        lsir_pkg::kind_t kind;
        logic [2:0]      arg;
    } plan_entry_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    tick_valid = 1'b0;
    logic    item_ready;
    lsir_pkg::item_t   tick_item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    lsir_pkg::result_t result_word;
    logic    cfg_write = 1'b0;
    logic [1:0]  cfg_index = lsir_pkg::REG_DEVICE_ADDRESS;
    logic [15:0] cfg_data = '0;

    // Items waiting to be driven, and bus ticks predicted but not yet seen.
    lsir_pkg::item_t   pending_ticks[$];
    lsir_pkg::result_t expected_ticks[$];

    // Predictor state: a private copy of the sequencer and the registers.
    lsir_pkg::cfg_t cfg_shadow;
    logic [5:0]  step_q;
    logic [1:0]  phase_q;
    logic [2:0]  bit_q;
    logic [7:0]  shift_q;
    logic [15:0] wait_count_q;
    logic [15:0] reading_q;
    logic [4:0]  nack_q;

    lsir_pkg::result_t predicted;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      idling_on = 1'b1;
    int      mismatches = 0;
    int      cycle_count = 0;

    light_sensor_i2c_reader_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (tick_valid),
        .item_ready   (item_ready),
        .item         (tick_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The fixed transaction plan: power-on write, mode write, the conversion
    // wait, then the two-byte read. Ack slot arguments are bit positions in
    // the NACK record.
    function automatic plan_entry_t plan_at(input logic [5:0] step);
        plan_entry_t e;
        case (step)
            6'd0, 6'd6, 6'd13: e = '{kind: lsir_pkg::K_START, arg: 3'd0};
            6'd1, 6'd7:        e = '{kind: lsir_pkg::K_WRITE, arg: BYTE_ADDR_WR};
            6'd2:              e = '{kind: lsir_pkg::K_ACK,   arg: 3'd0};
            6'd3:              e = '{kind: lsir_pkg::K_WRITE, arg: BYTE_POWER};
            6'd4:              e = '{kind: lsir_pkg::K_ACK,   arg: 3'd1};
            6'd5, 6'd11:       e = '{kind: lsir_pkg::K_STOP,  arg: STOP_PLAIN};
            6'd8:              e = '{kind: lsir_pkg::K_ACK,   arg: 3'd2};
            6'd9:              e = '{kind: lsir_pkg::K_WRITE, arg: BYTE_MODE};
            6'd10:             e = '{kind: lsir_pkg::K_ACK,   arg: 3'd3};
            6'd12:             e = '{kind: lsir_pkg::K_WAIT,  arg: 3'd0};
            6'd14:             e = '{kind: lsir_pkg::K_WRITE, arg: BYTE_ADDR_RD};
            6'd15:             e = '{kind: lsir_pkg::K_ACK,   arg: 3'd4};
            6'd16:             e = '{kind: lsir_pkg::K_READ,  arg: READ_HIGH};
            6'd17:             e = '{kind: lsir_pkg::K_HACK,  arg: HOST_ACK};
            6'd18:             e = '{kind: lsir_pkg::K_READ,  arg: READ_LOW};
            6'd19:             e = '{kind: lsir_pkg::K_HACK,  arg: HOST_NACK};
            default:           e = '{kind: lsir_pkg::K_STOP,  arg: STOP_FINAL};
        endcase
        return e;
    endfunction

    // Move the sequencer to the next plan element. Entering the wait clears
    // its counter; running past the last element returns to idle.
    task automatic next_element();
        phase_q = 2'd0;
        bit_q = 3'd0;
        step_q = step_q + 6'd1;
        if (step_q >= STEP_END)
            step_q = STEP_IDLE;
        else if (step_q == STEP_DELAY)
            wait_count_q = '0;
    endtask

    // One bus tick of the master: what it drives on the lines and what the
    // result registers show after this tick.
    task automatic predict_tick(input lsir_pkg::item_t it, output lsir_pkg::result_t r);
        plan_entry_t e;
        logic [1:0]  ph;
        logic        bitwise;
        logic        scl;
        logic        drv;
        logic        busy;
        logic        done;
        logic [31:0] lux_full;

        scl = 1'b1;
        drv = 1'b0;
        busy = 1'b0;
        done = 1'b0;
        bitwise = 1'b0;

        // A request only counts on an idle tick; it clears the NACK record and
        // this very tick drives the first start phase.
        if (step_q == STEP_IDLE && it.start_request)
        begin
            nack_q = '0;
            step_q = '0;
            phase_q = 2'd0;
            bit_q = 3'd0;
        end

        if (step_q != STEP_IDLE)
        begin
            busy = 1'b1;
            // The wait leaves the bus idle; once the count is reached the
            // third start begins on the same tick, so a zero wait costs nothing.
            if (step_q == STEP_DELAY)
            begin
                if (wait_count_q >= cfg_shadow.wait_ticks)
                    next_element();
                else
                    wait_count_q = wait_count_q + 16'd1;
            end
        end

        if (step_q != STEP_IDLE && step_q != STEP_DELAY)
        begin
            ph = (phase_q > 2'd2) ? 2'd2 : phase_q;
            e = plan_at(step_q);
            case (e.kind)
                lsir_pkg::K_START:
                begin
                    scl = (ph < 2'd2);
                    drv = (ph > 2'd0);
                end
                lsir_pkg::K_STOP:
                begin
                    scl = (ph > 2'd0);
                    drv = (ph < 2'd2);
                    if (e.arg == STOP_FINAL && ph == 2'd2)
                        done = 1'b1;
                end
                lsir_pkg::K_WRITE:
                begin
                    bitwise = 1'b1;
                    // The byte is taken from the registers at its first tick.
                    if (ph == 2'd0 && bit_q == 3'd0)
                    begin
                        case (e.arg)
                            BYTE_ADDR_WR: shift_q = {cfg_shadow.device_address, 1'b0};
                            BYTE_POWER:   shift_q = cfg_shadow.power_command;
                            BYTE_MODE:    shift_q = cfg_shadow.mode_command;
                            default:      shift_q = {cfg_shadow.device_address, 1'b1};
                        endcase
                    end
                    scl = (ph == 2'd1);
                    drv = ~shift_q[7];
                    if (ph == 2'd2)
                        shift_q = {shift_q[6:0], 1'b0};
                end
                lsir_pkg::K_ACK:
                begin
                    // The sensor NACKs by leaving the line high while the
                    // clock is high; the sequence carries on regardless.
                    scl = (ph == 2'd1);
                    drv = 1'b0;
                    if (ph == 2'd1 && it.sda_in)
                        nack_q[e.arg] = 1'b1;
                end
                lsir_pkg::K_READ:
                begin
                    bitwise = 1'b1;
                    scl = (ph == 2'd1);
                    drv = 1'b0;
                    if (ph == 2'd1)
                        shift_q = {shift_q[6:0], it.sda_in};
                    if (ph == 2'd2 && bit_q == 3'd7)
                    begin
                        if (e.arg == READ_HIGH)
                            reading_q[15:8] = shift_q;
                        else
                            reading_q[7:0] = shift_q;
                    end
                end
                default:
                begin
                    scl = (ph == 2'd1);
                    drv = (e.arg == HOST_ACK);
                end
            endcase
            if (ph == 2'd2)
            begin
                if (bitwise && bit_q < 3'd7)
                begin
                    phase_q = 2'd0;
                    bit_q = bit_q + 3'd1;
                end
                else
                begin
                    next_element();
                end
            end
            else
            begin
                phase_q = ph + 2'd1;
            end
        end

        lux_full = ({16'd0, reading_q} * 32'd640) / 32'd3;
        r.scl_level = scl;
        r.sda_drive_low = drv;
        r.busy_res = busy;
        r.done_res = done;
        r.raw_count = reading_q;
        r.lux_q8 = lux_full[23:0];
        r.nack_flags = nack_q;
    endtask

    // Driver. Items leave the pending queue one per transfer; each transfer
    // is run through the predictor at the edge where it is accepted. Gaps are
    // inserted at random while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            tick_item <= '0;
            send_gap = 0;
        end
        else
        begin
            if (tick_valid && item_ready)
            begin
                predict_tick(tick_item, predicted);
                expected_ticks.push_back(predicted);
            end
            if (!tick_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    tick_valid <= 1'b0;
                end
                else if (pending_ticks.size() == 0)
                begin
                    tick_valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 9);
                    tick_valid <= 1'b0;
                end
                else
                begin
                    tick_valid <= 1'b1;
                    tick_item <= pending_ticks.pop_front();
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor. Every result transfer is matched against the oldest predicted
    // tick, field by field. The receiver stalls in random bursts as well.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, result_word);
                    mismatches++;
                end
                else
                begin
                    predicted = expected_ticks.pop_front();
                    check_field("scl_level", 24'(predicted.scl_level),
                                24'(result_word.scl_level));
                    check_field("sda_drive_low", 24'(predicted.sda_drive_low),
                                24'(result_word.sda_drive_low));
                    check_field("busy_res", 24'(predicted.busy_res),
                                24'(result_word.busy_res));
                    check_field("done_res", 24'(predicted.done_res),
                                24'(result_word.done_res));
                    check_field("raw_count", 24'(predicted.raw_count),
                                24'(result_word.raw_count));
                    check_field("lux_q8", predicted.lux_q8, result_word.lux_q8);
                    check_field("nack_flags", 24'(predicted.nack_flags),
                                24'(result_word.nack_flags));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Write all four registers, one per cycle, while the block is idle.
    task automatic program_regs(input lsir_pkg::cfg_t c);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= lsir_pkg::REG_DEVICE_ADDRESS;
        cfg_data <= {9'd0, c.device_address};
        @(posedge clk);
        cfg_index <= lsir_pkg::REG_POWER_COMMAND;
        cfg_data <= {8'd0, c.power_command};
        @(posedge clk);
        cfg_index <= lsir_pkg::REG_MODE_COMMAND;
        cfg_data <= {8'd0, c.mode_command};
        @(posedge clk);
        cfg_index <= lsir_pkg::REG_WAIT_TICKS;
        cfg_data <= c.wait_ticks;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_shadow = c;
    endtask

    // Write only the conversion wait, leaving the other registers as they are.
    task automatic program_wait(input logic [15:0] w);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= lsir_pkg::REG_WAIT_TICKS;
        cfg_data <= w;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_shadow.wait_ticks = w;
    endtask

    // Ticks with no request: the block either idles or finishes its sequence.
    task automatic queue_noise(input int count);
        lsir_pkg::item_t it;
        repeat (count)
        begin
            it.start_request = 1'b0;
            it.sda_in = 1'($urandom_range(0, 1));
            pending_ticks.push_back(it);
        end
    endtask

    // One complete measurement: the request tick and exactly as many further
    // ticks as the sequence runs with the current wait setting.
    task automatic queue_measurement(input int sda_mode, input int req_mode);
        lsir_pkg::item_t it;
        int    span;

        span = SEQ_TICKS + cfg_shadow.wait_ticks;
        for (int i = 0; i < span; i++)
        begin
            if (i == 0 || req_mode == REQ_HOLD)
                it.start_request = 1'b1;
            else
                it.start_request = ($urandom_range(0, 15) == 0);
            case (sda_mode)
                SDA_HIGH: it.sda_in = 1'b1;
                SDA_LOW:  it.sda_in = 1'b0;
                default:  it.sda_in = 1'($urandom_range(0, 1));
            endcase
            pending_ticks.push_back(it);
        end
    endtask

    // Checked on the falling edge, where every handshake of the last rising
    // edge has fully settled.
    task automatic wait_drain();
        while (pending_ticks.size() != 0 || tick_valid || expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    // Let every transfer finish, then pad with request-free ticks until the
    // predicted sequencer is back at idle, so registers may be written.
    task automatic settle();
        wait_drain();
        while (step_q != STEP_IDLE)
        begin
            queue_noise(64);
            wait_drain();
        end
    endtask

    function automatic logic [15:0] pick_wait();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 2));
        return 16'($urandom_range(3, 40));
    endfunction

    initial
    begin
        lsir_pkg::cfg_t c;
        int   sda_pick;

        // Register values after reset, mirrored in the predictor.
        cfg_shadow = '{device_address: 7'd35, power_command: 8'd1,
                       mode_command: 8'd16, wait_ticks: 16'd36000};
        step_q = STEP_IDLE;
        phase_q = 2'd0;
        bit_q = 3'd0;
        shift_q = '0;
        wait_count_q = '0;
        reading_q = '0;
        nack_q = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the reset address and command bytes with a short wait.
        // The sensor never acknowledges and the line reads all ones, so every
        // NACK flag sets and the reading is full scale. The request is held
        // for the whole sequence, so requests while busy must be ignored.
        program_wait(16'd5);
        queue_noise(3);
        queue_measurement(SDA_HIGH, REQ_HOLD);
        queue_noise(2);
        settle();

        // Directed: lowest register values and a zero wait. The first
        // measurement sees every slot acknowledged and a zero reading, and the
        // second starts on the tick right after the final stop.
        c = '{device_address: 7'd0, power_command: 8'd0, mode_command: 8'd0,
              wait_ticks: 16'd0};
        program_regs(c);
        queue_measurement(SDA_LOW, REQ_SPARSE);
        queue_measurement(SDA_HIGH, REQ_SPARSE);
        queue_noise(2);
        settle();

        // Directed: highest register values with a moderate wait.
        c = '{device_address: 7'd127, power_command: 8'd255, mode_command: 8'd255,
              wait_ticks: 16'd48};
        program_regs(c);
        queue_measurement(SDA_RANDOM, REQ_SPARSE);
        settle();

        // Random phases: fresh registers each phase with short waits, then one or
        // two measurements with random sensor behavior, some back to back and
        // some separated by idle ticks.
        repeat (2)
        begin
            c.device_address = 7'($urandom_range(0, 127));
            c.power_command = 8'($urandom_range(0, 255));
            c.mode_command = 8'($urandom_range(0, 255));
            c.wait_ticks = pick_wait();
            program_regs(c);
            repeat ($urandom_range(1, 2))
            begin
                queue_noise($urandom_range(0, 5));
                sda_pick = $urandom_range(0, 5);
                if (sda_pick == 0)
                    queue_measurement(SDA_HIGH, REQ_SPARSE);
                else if (sda_pick == 1)
                    queue_measurement(SDA_LOW, REQ_SPARSE);
                else
                    queue_measurement(SDA_RANDOM, REQ_SPARSE);
            end
            settle();
        end

        // Closing phase at full rate on both sides.
        idling_on = 1'b0;
        c.device_address = 7'($urandom_range(0, 127));
        c.power_command = 8'($urandom_range(0, 255));
        c.mode_command = 8'($urandom_range(0, 255));
        c.wait_ticks = pick_wait();
        program_regs(c);
        queue_measurement(SDA_RANDOM, REQ_SPARSE);
        queue_measurement(SDA_RANDOM, REQ_SPARSE);
        settle();

        // Give any stray result time to show up before the verdict.
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lsir_pkg.sv
hdl/lsir_seq.sv
hdl/lsir_lux.sv
hdl/light_sensor_i2c_reader_unit.sv
tb/tb_light_sensor_i2c_reader_unit.sv
